// ----- rtl/adf_pkg.sv -----
`timescale 1ns / 1ps

package adf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CODE_W     = 10;
    localparam int LEVEL_W    = 11;
    localparam int PERIOD_W   = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // result queue behind the memory read stage
    localparam int Q_DEPTH = 3;
    localparam int QCNT_W  = 2;
    localparam int QPTR_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DOWNMIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 1'b1;

    // offset-binary midscale, also the underrun code
    localparam logic [CODE_W-1:0] CODE_MID = 10'h200;

    typedef struct packed {
        logic                dac_valid;
        logic [CODE_W-1:0]   dac_code;
        logic                underrun;
        logic                push_accepted;
        logic [LEVEL_W-1:0]  fifo_level;
        logic                running;
    } res_t;

    // (l + r) / 2, truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] downmix_avg(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        logic signed [SAMPLE_W:0] sum;
        logic signed [SAMPLE_W:0] adj;
        sum = (SAMPLE_W+1)'(l) + (SAMPLE_W+1)'(r);
        adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
        return adj[SAMPLE_W:1];
    endfunction

    // s / 64 truncated toward zero, then offset by midscale
    function automatic logic [CODE_W-1:0] dac_convert(
        input logic signed [SAMPLE_W-1:0] s
    );
        logic signed [SAMPLE_W-1:0] adj;
        logic [CODE_W-1:0]          quo;
        adj = s + (s[SAMPLE_W-1] ? 16'sd63 : 16'sd0);
        quo = adj[SAMPLE_W-1:6];
        return {~quo[CODE_W-1], quo[CODE_W-2:0]};
    endfunction

endpackage

// ----- rtl/adf_if.sv -----
`timescale 1ns / 1ps

interface adf_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [adf_pkg::OP_W-1:0]             opcode;
    logic signed [adf_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [adf_pkg::SAMPLE_W-1:0]  right_sample;
    logic                                 last_in_block;

    modport source (output valid, opcode, left_sample, right_sample, last_in_block,
                    input ready);
    modport sink (input valid, opcode, left_sample, right_sample, last_in_block,
                  output ready);
endinterface

interface adf_result_if;
    logic                              valid;
    logic                              ready;
    logic                              dac_valid;
    logic [adf_pkg::CODE_W-1:0]        dac_code;
    logic                              underrun;
    logic                              push_accepted;
    logic [adf_pkg::LEVEL_W-1:0]       fifo_level;
    logic                              running;

    modport source (output valid, dac_valid, dac_code, underrun, push_accepted,
                    fifo_level, running, input ready);
    modport sink (input valid, dac_valid, dac_code, underrun, push_accepted,
                  fifo_level, running, output ready);
endinterface

interface adf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [adf_pkg::CFG_IDX_W-1:0]       index;
    logic [adf_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/adf_res_queue.sv -----
`timescale 1ns / 1ps

module adf_res_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  adf_pkg::res_t                push_data,
    output logic [adf_pkg::QCNT_W-1:0]   count,
    adf_result_if.source                 out
);

    localparam logic [adf_pkg::QPTR_W-1:0] PTR_LAST = adf_pkg::QPTR_W'(adf_pkg::Q_DEPTH - 1);

    adf_pkg::res_t                    slot_reg [adf_pkg::Q_DEPTH];
    logic [adf_pkg::QPTR_W-1:0]       head_reg, head_next;
    logic [adf_pkg::QPTR_W-1:0]       tail_reg, tail_next;
    logic [adf_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             pop;
    adf_pkg::res_t                    head_beat;

    assign pop       = out.valid && out.ready;
    assign head_beat = slot_reg[head_reg];
    assign count     = count_reg;

    assign out.valid         = (count_reg != '0);
    assign out.dac_valid     = head_beat.dac_valid;
    assign out.dac_code      = head_beat.dac_code;
    assign out.underrun      = head_beat.underrun;
    assign out.push_accepted = head_beat.push_accepted;
    assign out.fifo_level    = head_beat.fifo_level;
    assign out.running       = head_beat.running;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_valid)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (push_valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == adf_pkg::QCNT_W'(adf_pkg::Q_DEPTH)) |-> (!push_valid || pop))
        else $error("result queue overflow");

    a_part_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1 || count_reg == 2'd2) |-> (head_reg != tail_reg))
        else $error("result queue pointers disagree with count");

    a_edge_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd3) |-> (head_reg == tail_reg))
        else $error("result queue pointers disagree with count");

endmodule

// ----- rtl/audio_dac_sample_fifo.sv -----
`timescale 1ns / 1ps

// channel     dir  beat
// sample_in   in   opcode, left_sample, right_sample, last_in_block
// cfg         in   index (0 downmix_stereo, 1 period_match), data
// result_out  out  dac_valid, dac_code, underrun, push_accepted, fifo_level, running
//
// one input beat per cycle sustained while input ready stays high; each beat yields exactly
// one result beat, registered in the sample-store access stage and then in the result queue
// the rate is set by the single write port and single read port of the sample store
// reset clears pointers, tick counter and run state; the sample store is not cleared
// a stalled result side backs up into a 3-entry result queue before input ready drops
// cfg is always ready and takes effect on the next item

module audio_dac_sample_fifo #(
    parameter int FIFO_DEPTH = 2048
) (
    input  logic           clk,
    input  logic           rst_n,
    adf_sample_if.sink     sample_in,
    adf_cfg_if.sink        cfg,
    adf_result_if.source   result_out
);

    localparam int              PTR_W    = $clog2(FIFO_DEPTH);
    localparam int              LVL_W    = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [LVL_W-1:0] DEPTH_LV = LVL_W'(FIFO_DEPTH);

    // sample store, read data registered
    logic signed [adf_pkg::SAMPLE_W-1:0] store_mem [FIFO_DEPTH];
    logic signed [adf_pkg::SAMPLE_W-1:0] rd_data_reg;

    // ring and output timing state
    logic [PTR_W-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [adf_pkg::PERIOD_W-1:0]  tick_reg, tick_next;
    logic                          active_reg, active_next;
    logic                          stop_reg, stop_next;

    // configuration
    logic                          downmix_reg;
    logic [adf_pkg::PERIOD_W-1:0]  period_reg;

    // store access stage
    logic                          a_valid_reg;
    logic                          a_pop_reg;
    adf_pkg::res_t                 a_res_reg;

    logic                          accept;
    logic                          do_write;
    logic                          do_pop;
    logic signed [adf_pkg::SAMPLE_W-1:0] push_sample;
    logic [PTR_W-1:0]              wr_ptr_inc;
    logic [PTR_W-1:0]              rd_ptr_inc;
    logic                          ring_full;
    logic                          ring_empty;
    logic [LVL_W-1:0]              level;
    adf_pkg::res_t                 res;
    adf_pkg::res_t                 q_beat;
    logic [adf_pkg::QCNT_W-1:0]    q_count;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            downmix_reg <= 1'b0;
            period_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                adf_pkg::CFG_DOWNMIX: downmix_reg <= cfg.data[0];
                adf_pkg::CFG_PERIOD:  period_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input side: room is counted over the access stage and the queue,
    // so a result always finds a slot without looking at result_out.ready
    // ---------------------------------------------------------------
    assign sample_in.ready = (q_count < 2'd2) || (q_count == 2'd2 && !a_valid_reg);
    assign accept          = sample_in.valid && sample_in.ready;

    assign push_sample = downmix_reg
        ? adf_pkg::downmix_avg(sample_in.left_sample, sample_in.right_sample)
        : sample_in.left_sample;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign ring_full  = (wr_ptr_inc == rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);

    // ---------------------------------------------------------------
    // item decode: pointer, timer and run state update in the accept cycle
    // ---------------------------------------------------------------
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        tick_next   = tick_reg;
        active_next = active_reg;
        stop_next   = stop_reg;
        do_write    = 1'b0;
        do_pop      = 1'b0;
        res         = '0;

        if (accept)
        begin
            case (sample_in.opcode)
                adf_pkg::OP_PUSH:
                begin
                    // a full ring drops the sample, a block end still starts output
                    if (!ring_full)
                    begin
                        do_write          = 1'b1;
                        wr_ptr_next       = wr_ptr_inc;
                        res.push_accepted = 1'b1;
                    end
                    if (sample_in.last_in_block)
                    begin
                        active_next = 1'b1;
                    end
                end
                adf_pkg::OP_TICK:
                begin
                    if (active_reg)
                    begin
                        if (tick_reg == period_reg)
                        begin
                            tick_next     = '0;
                            res.dac_valid = 1'b1;
                            res.dac_code  = adf_pkg::CODE_MID;
                            if (!ring_empty)
                            begin
                                do_pop      = 1'b1;
                                rd_ptr_next = rd_ptr_inc;
                            end
                            else
                            begin
                                res.underrun = 1'b1;
                            end
                            // pending drain finishes on the pop that empties the ring
                            if (stop_reg && wr_ptr_reg == rd_ptr_next)
                            begin
                                active_next = 1'b0;
                                stop_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                adf_pkg::OP_DRAIN:
                begin
                    if (!active_reg)
                    begin
                        stop_next = 1'b0;
                    end
                    else if (ring_empty)
                    begin
                        active_next = 1'b0;
                        stop_next   = 1'b0;
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
                default: ;
            endcase

            res.fifo_level = adf_pkg::LEVEL_W'(level);
            res.running    = active_next;
        end
    end

    // fill level after the item
    always_comb
    begin
        level = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        if (wr_ptr_next < rd_ptr_next)
        begin
            level = level + DEPTH_LV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            tick_reg    <= '0;
            active_reg  <= 1'b0;
            stop_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            tick_reg    <= tick_next;
            active_reg  <= active_next;
            stop_reg    <= stop_next;
            a_valid_reg <= accept;
        end
    end

    // ---------------------------------------------------------------
    // sample store: one write, one registered read per cycle; a pop never
    // shares a cycle with the push of its entry, so no bypass is needed
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[wr_ptr_reg] <= push_sample;
        end
        if (do_pop)
        begin
            rd_data_reg <= store_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pop_reg <= do_pop;
            a_res_reg <= res;
        end
    end

    // ---------------------------------------------------------------
    // convert the popped sample and hand the beat to the result queue
    // ---------------------------------------------------------------
    always_comb
    begin
        q_beat = a_res_reg;
        if (a_pop_reg)
        begin
            q_beat.dac_code = adf_pkg::dac_convert(rd_data_reg);
        end
    end

    adf_res_queue u_res_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (a_valid_reg),
        .push_data  (q_beat),
        .count      (q_count),
        .out        (result_out)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_stop_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> active_reg)
        else $error("drain pending while output stopped");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
        else $error("ring pointer out of range");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (q_count < adf_pkg::QCNT_W'(adf_pkg::Q_DEPTH)
                         || (result_out.valid && result_out.ready)))
        else $error("result beat with no queue room");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> !ring_empty)
        else $error("pop from empty ring");

endmodule

// ----- tb/adf_checker.sv -----
`timescale 1ns / 1ps

module adf_checker #(
    parameter int RING_DEPTH = 2048
) (
    input  logic  clk,
    input  logic  rst_n,
    adf_sample_if sample_mon,
    adf_cfg_if    cfg_mon,
    adf_result_if result_mon,
    output int    failures,
    output int    outstanding,
    output int    refusals,
    output int    underruns
);

    logic signed [adf_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned                         wr_ptr;
    int unsigned                         rd_ptr;
    logic [adf_pkg::PERIOD_W-1:0]        tick_count;
    logic                                out_active;
    logic                                stop_pending;
    logic                                downmix;
    logic [adf_pkg::PERIOD_W-1:0]        period_match;

    // one entry per accepted sample beat, oldest first
    adf_pkg::res_t due_results[$];

    function automatic int unsigned ring_next(input int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_level();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + RING_DEPTH - rd_ptr;
    endfunction

    // advances the ring and the output timer by one beat, returns the result beat
    function automatic adf_pkg::res_t step_sample_ring(
        input logic [adf_pkg::OP_W-1:0]           op,
        input logic signed [adf_pkg::SAMPLE_W-1:0] l,
        input logic signed [adf_pkg::SAMPLE_W-1:0] r,
        input logic                                last
    );
        adf_pkg::res_t res;
        int            s;
        res = '0;
        case (op)
            adf_pkg::OP_PUSH:
            begin
                s = downmix ? (int'(l) + int'(r)) / 2 : int'(l);
                if (ring_next(wr_ptr) != rd_ptr)
                begin
                    ring[wr_ptr]      = adf_pkg::SAMPLE_W'(s);
                    wr_ptr            = ring_next(wr_ptr);
                    res.push_accepted = 1'b1;
                end
                else
                begin
                    refusals++;
                end
                if (last)
                    out_active = 1'b1;
            end
            adf_pkg::OP_TICK:
            begin
                if (out_active)
                begin
                    if (tick_count == period_match)
                    begin
                        s             = 0;
                        tick_count    = '0;
                        res.dac_valid = 1'b1;
                        if (wr_ptr != rd_ptr)
                        begin
                            s      = int'(ring[rd_ptr]);
                            rd_ptr = ring_next(rd_ptr);
                        end
                        else
                        begin
                            res.underrun = 1'b1;
                            underruns++;
                        end
                        res.dac_code = adf_pkg::CODE_W'(s / 64 + 512);
                        if (stop_pending && wr_ptr == rd_ptr)
                        begin
                            out_active   = 1'b0;
                            stop_pending = 1'b0;
                        end
                    end
                    else
                    begin
                        tick_count = tick_count + 1'b1;
                    end
                end
            end
            adf_pkg::OP_DRAIN:
            begin
                if (!out_active)
                begin
                    stop_pending = 1'b0;
                end
                else if (wr_ptr == rd_ptr)
                begin
                    out_active   = 1'b0;
                    stop_pending = 1'b0;
                end
                else
                begin
                    stop_pending = 1'b1;
                end
            end
            default: ;
        endcase
        res.fifo_level = adf_pkg::LEVEL_W'(ring_level());
        res.running    = out_active;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int seen);
        $display("%0t ns  mismatch on %s: want %0d, got %0d", $time, field, want, seen);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        adf_pkg::res_t got;
        adf_pkg::res_t want;
        if (!rst_n)
        begin
            wr_ptr       = 0;
            rd_ptr       = 0;
            tick_count   = '0;
            out_active   = 1'b0;
            stop_pending = 1'b0;
            downmix      = 1'b0;
            period_match = '0;
            failures     = 0;
            refusals     = 0;
            underruns    = 0;
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                got.dac_valid     = result_mon.dac_valid;
                got.dac_code      = result_mon.dac_code;
                got.underrun      = result_mon.underrun;
                got.push_accepted = result_mon.push_accepted;
                got.fifo_level    = result_mon.fifo_level;
                got.running       = result_mon.running;
                if (due_results.size() == 0)
                begin
                    report_mismatch("result beat with no sample beat behind it", 0, 1);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.dac_valid !== want.dac_valid)
                        report_mismatch("dac_valid", want.dac_valid, got.dac_valid);
                    if (got.dac_code !== want.dac_code)
                        report_mismatch("dac_code", want.dac_code, got.dac_code);
                    if (got.underrun !== want.underrun)
                        report_mismatch("underrun", want.underrun, got.underrun);
                    if (got.push_accepted !== want.push_accepted)
                        report_mismatch("push_accepted", want.push_accepted,
                                        got.push_accepted);
                    if (got.fifo_level !== want.fifo_level)
                        report_mismatch("fifo_level", want.fifo_level, got.fifo_level);
                    if (got.running !== want.running)
                        report_mismatch("running", want.running, got.running);
                end
            end
            if (sample_mon.valid && sample_mon.ready)
                due_results.push_back(step_sample_ring(sample_mon.opcode,
                    sample_mon.left_sample, sample_mon.right_sample,
                    sample_mon.last_in_block));
            // register writes apply from the next sample beat on
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    adf_pkg::CFG_DOWNMIX: downmix      = cfg_mon.data[0];
                    adf_pkg::CFG_PERIOD:  period_match = cfg_mon.data;
                    default: ;
                endcase
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int RING_DEPTH = 2048;
    // opcode with no function, the block only reports level and run state
    localparam logic [adf_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int PHASE_BEATS = 20;

    logic clk = 1'b0;
    logic rst_n;

    adf_sample_if sample_in ();
    adf_cfg_if    cfg ();
    adf_result_if result_out ();

    int fail_count;
    int due_count;
    int refused_count;
    int underrun_count;

    // sender and receiver idle chances, in percent per cycle
    int tx_idle_pct;
    int rx_idle_pct;

    int beats_sent;
    int settings_used;
    int push_weight;
    int block_left;
    logic [adf_pkg::PERIOD_W-1:0] period_now;

    audio_dac_sample_fifo #(
        .FIFO_DEPTH (RING_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .cfg        (cfg),
        .result_out (result_out)
    );

    adf_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_mon  (sample_in),
        .cfg_mon     (cfg),
        .result_mon  (result_out),
        .failures    (fail_count),
        .outstanding (due_count),
        .refusals    (refused_count),
        .underruns   (underrun_count)
    );

    always #5 clk = ~clk;

    // receiver side: random back-pressure on the result channel
    always @(posedge clk)
        result_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // pcm value, now and then one of the range corners
    function automatic logic signed [adf_pkg::SAMPLE_W-1:0] pcm_value();
        if ($urandom_range(0, 15) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return adf_pkg::SAMPLE_W'($urandom);
    endfunction

    // one sample-channel beat, with random idle cycles ahead of it;
    // valid stays high across back-to-back beats
    task automatic send_beat(
        input logic [adf_pkg::OP_W-1:0]           op,
        input logic signed [adf_pkg::SAMPLE_W-1:0] l,
        input logic signed [adf_pkg::SAMPLE_W-1:0] r,
        input logic                                last
    );
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_in.valid <= 1'b0;
            @(posedge clk);
        end
        sample_in.valid         <= 1'b1;
        sample_in.opcode        <= op;
        sample_in.left_sample   <= l;
        sample_in.right_sample  <= r;
        sample_in.last_in_block <= last;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic tick_beats(input int n);
        repeat (n)
            send_beat(adf_pkg::OP_TICK, pcm_value(), pcm_value(), 1'($urandom));
    endtask

    // hold off the sender until every result beat has come back
    task automatic settle();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    // both registers back to back, only while the block is idle
    task automatic write_config(input logic mix,
                                input logic [adf_pkg::PERIOD_W-1:0] period);
        cfg.valid <= 1'b1;
        cfg.index <= adf_pkg::CFG_DOWNMIX;
        cfg.data  <= {{(adf_pkg::CFG_DATA_W-1){1'b0}}, mix};
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.index <= adf_pkg::CFG_PERIOD;
        cfg.data  <= period;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    // mostly ticks, interleaved with blocks of pushes closed by last_in_block;
    // some drains, a few spare opcodes and stray block ends as noise
    task automatic random_beat();
        int                                  pick;
        logic signed [adf_pkg::SAMPLE_W-1:0] l;
        logic signed [adf_pkg::SAMPLE_W-1:0] r;
        logic                                last;
        pick = $urandom_range(0, 99);
        l    = pcm_value();
        r    = pcm_value();
        last = ($urandom_range(0, 19) == 0);
        if (pick < push_weight)
        begin
            block_left--;
            if (block_left <= 0)
            begin
                last       = 1'b1;
                block_left = $urandom_range(1, 8);
            end
            send_beat(adf_pkg::OP_PUSH, l, r, last);
        end
        else if (pick < push_weight + 4)
        begin
            send_beat(adf_pkg::OP_DRAIN, l, r, last);
        end
        else if (pick < push_weight + 6)
        begin
            send_beat(OP_SPARE, l, r, last);
        end
        else
        begin
            send_beat(adf_pkg::OP_TICK, l, r, last);
        end
    endtask

    // one setting of the registers, then random beats with a full pause halfway
    task automatic run_phase(input logic mix, input logic [adf_pkg::PERIOD_W-1:0] period,
                             input int n);
        settle();
        write_config(mix, period);
        push_weight = $urandom_range(15, 40);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                settle();
            random_beat();
        end
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sample_in.valid         <= 1'b0;
        sample_in.opcode        <= adf_pkg::OP_TICK;
        sample_in.left_sample   <= '0;
        sample_in.right_sample  <= '0;
        sample_in.last_in_block <= 1'b0;
        cfg.valid               <= 1'b0;
        cfg.index               <= adf_pkg::CFG_DOWNMIX;
        cfg.data                <= '0;
        rst_n                   <= 1'b0;
        beats_sent    = 0;
        settings_used = 0;
        block_left    = 4;
        period_now    = '0;
        // first stretch: sender idles 32 percent, receiver 51 percent
        tx_idle_pct   = 32;
        rx_idle_pct   = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // stopped and empty after reset, tick counter at zero
        write_config(1'b0, '0);
        settle();
        send_beat(adf_pkg::OP_TICK, 16'sh7FFF, 16'sh8000, 1'b1);   // tick while stopped
        send_beat(adf_pkg::OP_DRAIN, 16'sh8000, 16'sh7FFF, 1'b0);  // drain while stopped
        send_beat(adf_pkg::OP_PUSH, 16'sh7FFF, 16'sh0000, 1'b0);   // top dac code
        send_beat(adf_pkg::OP_PUSH, 16'sh8000, 16'sh7FFF, 1'b0);   // bottom dac code
        send_beat(adf_pkg::OP_PUSH, -16'sd65, 16'sh0000, 1'b0);    // negative, toward zero
        send_beat(adf_pkg::OP_PUSH, 16'sd63, -16'sd1, 1'b1);       // block end starts output
        send_beat(OP_SPARE, 16'sh7FFF, -16'sd1, 1'b1);             // spare opcode, no effect
        send_beat(adf_pkg::OP_DRAIN, 16'sh0000, 16'sh0000, 1'b0);  // stop pending
        send_beat(adf_pkg::OP_PUSH, 16'sh0000, -16'sd1, 1'b0);     // push keeps it pending
        tick_beats(5);                                             // last pop stops output

        // downmix corners: sums that overflow 16 bits and odd negative sums
        settle();
        write_config(1'b1, '0);
        send_beat(adf_pkg::OP_PUSH, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_beat(adf_pkg::OP_PUSH, 16'sh8000, 16'sh8000, 1'b0);
        send_beat(adf_pkg::OP_PUSH, 16'sh7FFF, 16'sh8000, 1'b0);
        send_beat(adf_pkg::OP_PUSH, -16'sd1, -16'sd2, 1'b1);
        tick_beats(5);                                    // four pops and an underrun
        // drain while running and empty stops output at once
        send_beat(adf_pkg::OP_DRAIN, 16'sh0000, 16'sh0000, 1'b0);

        // random phases; period_match never drops, since the tick counter is
        // only cleared on a match and a smaller match would leave it behind
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 32;
            end
            else if (ph == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            period_now = period_now + $urandom_range(0, 2);
            run_phase(1'($urandom), period_now, PHASE_BEATS);
        end

        // all-ones match last: the counter climbs and never fires
        run_phase(1'($urandom), '1, 20);

        // with no pops left, fill the ring to its limit of depth minus one,
        // the last pushes are refused and the final one closes a block
        for (int i = 0; i < RING_DEPTH + 1; i++)
            send_beat(adf_pkg::OP_PUSH, pcm_value(), pcm_value(), i == RING_DEPTH);
        tick_beats(4);
        send_beat(adf_pkg::OP_DRAIN, 16'sh0000, 16'sh0000, 1'b0);  // stop pending, full
        send_beat(adf_pkg::OP_PUSH, 16'sh1234, 16'sh0000, 1'b0);   // refused while full

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d sample beats under %0d register settings, mono and downmix,",
                 beats_sent, settings_used);
        $display("period_match from 0 to all ones, %0d refused pushes, %0d underrun codes",
                 refused_count, underrun_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/adf_pkg.sv
rtl/adf_if.sv
rtl/adf_res_queue.sv
rtl/audio_dac_sample_fifo.sv
tb/adf_checker.sv
tb/testbench.sv
